FILE: rtl/bat_pkg.sv
// ----------------------------------------------------------------------------
// bat_pkg
// Shared types, field widths and result codes of the blame accumulator table.
// ----------------------------------------------------------------------------
package bat_pkg;

	localparam int TABLE_DEPTH_DEF = 128 * 1024;
	localparam int ADDR_W          = 32;
	localparam int ID_W            = 30;
	localparam int BLAME_W         = 32;
	localparam int STATUS_W        = 3;
	localparam int QUEUE_DEPTH     = 4;

	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic [STATUS_W-1:0] ST_ADD_MATCH  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ADD_INSERT = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ADD_DROP   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_READ_HIT   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_READ_MISS  = 3'd4;

	typedef struct packed {
		logic               cmd;
		logic [ID_W-1:0]    id;
		logic [BLAME_W-1:0] amount;
	} item_t;

	// Identifier zero marks an empty entry
	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [BLAME_W-1:0] blame;
	} entry_t;

endpackage

FILE: rtl/bat_front.sv
// ----------------------------------------------------------------------------
// bat_front
// Accepts command beats, extracts the object identifier and reduces it to a
// table index (identifier modulo depth) in a three-stage reciprocal pipeline.
// ----------------------------------------------------------------------------
module bat_front #(
	parameter int TABLE_DEPTH = bat_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                command,
	input  logic [bat_pkg::ADDR_W-1:0]          object_address,
	input  logic [bat_pkg::BLAME_W-1:0]         metric_amount,
	input  logic                                block,
	input  logic                                q_full,
	output logic                                push,
	output bat_pkg::item_t                      push_item,
	output logic [$clog2(TABLE_DEPTH)-1:0]      push_idx
);

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int ID_W   = bat_pkg::ID_W;
	localparam int SHIFT  = ID_W + IDX_W;
	localparam int RECIP_W = ID_W + 1;
	localparam int PROD_W = ID_W + RECIP_W;
	localparam int D_W    = IDX_W + 1;
	localparam int QD_W   = ID_W + D_W;
	// ceil(2^SHIFT / depth): exact quotient for every identifier
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << SHIFT) + 64'(TABLE_DEPTH) - 64'd1) / 64'(TABLE_DEPTH));

	logic                 advance;
	logic                 accept;
	logic                 valid_s1, valid_s2, valid_s3;
	bat_pkg::item_t       item_s1, item_s2, item_s3;
	logic [PROD_W-1:0]    prod_s2;
	logic [IDX_W-1:0]     idx_s3;
	logic [PROD_W-1:0]    quo_full;
	logic [ID_W-1:0]      quo;
	logic [QD_W-1:0]      quo_d;
	logic [ID_W-1:0]      rem;

	// The whole pipeline holds when the last stage cannot enter the queue
	assign advance  = !(valid_s3 && q_full);
	assign in_stall = block || !advance;
	assign accept   = in_valid && !in_stall;

	assign quo_full = prod_s2 >> SHIFT;
	assign quo      = quo_full[ID_W-1:0];
	assign quo_d    = QD_W'(quo) * QD_W'(TABLE_DEPTH);
	assign rem      = item_s2.id - quo_d[ID_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_s1.cmd    <= command;
			item_s1.id     <= object_address[bat_pkg::ADDR_W-1:2];
			item_s1.amount <= metric_amount;
			item_s2        <= item_s1;
			prod_s2        <= PROD_W'(item_s1.id) * PROD_W'(RECIP);
			item_s3        <= item_s2;
			idx_s3         <= rem[IDX_W-1:0];
		end
	end

	assign push      = valid_s3 && !q_full;
	assign push_item = item_s3;
	assign push_idx  = idx_s3;

endmodule

FILE: rtl/bat_queue.sv
// ----------------------------------------------------------------------------
// bat_queue
// Small FIFO that decouples the index front end from the table update.
// ----------------------------------------------------------------------------
module bat_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic         full,
	output logic         not_empty,
	output logic [W-1:0] head
);

	localparam int PTR_W = $clog2(bat_pkg::QUEUE_DEPTH);
	localparam int CNT_W = PTR_W + 1;

	logic [W-1:0]     slot_q [bat_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full      = count_q == CNT_W'(bat_pkg::QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_data;
	end

endmodule

FILE: rtl/bat_back.sv
// ----------------------------------------------------------------------------
// bat_back
// Table memory with read-modify-write update, write-to-read forwarding,
// a clearing sweep after reset and the result register.
// ----------------------------------------------------------------------------
module bat_back #(
	parameter int TABLE_DEPTH = bat_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                head_valid,
	input  bat_pkg::item_t                      head_item,
	input  logic [$clog2(TABLE_DEPTH)-1:0]      head_idx,
	output logic                                pop,
	output logic                                clear_busy,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [bat_pkg::BLAME_W-1:0]         blame_value,
	output logic [bat_pkg::STATUS_W-1:0]        status
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	bat_pkg::entry_t mem [TABLE_DEPTH];
	bat_pkg::entry_t rd_data_q;

	logic            clearing_q;
	logic [IDX_W-1:0] clr_idx_q;

	logic            valid_s1;
	bat_pkg::item_t  item_s1;
	logic [IDX_W-1:0] idx_s1;
	logic            fwd_sel_s1;
	bat_pkg::entry_t fwd_data_s1;

	logic            out_valid_q;
	logic [bat_pkg::BLAME_W-1:0]  value_q;
	logic [bat_pkg::STATUS_W-1:0] status_q;

	logic            advance;
	bat_pkg::entry_t cur;
	bat_pkg::entry_t new_entry;
	logic            upd;
	logic [bat_pkg::BLAME_W-1:0]  value_nxt;
	logic [bat_pkg::STATUS_W-1:0] status_nxt;
	logic            item_wr;
	logic            mem_we;
	logic [IDX_W-1:0] mem_waddr;
	bat_pkg::entry_t mem_wdata;

	assign advance = !out_valid_q || !out_stall;
	assign pop     = advance && head_valid && !clearing_q;
	assign item_wr = valid_s1 && advance && upd;

	// Take the entry written at the same edge as this beat's read
	assign cur = fwd_sel_s1 ? fwd_data_s1 : rd_data_q;

	always_comb begin
		new_entry  = '0;
		upd        = 1'b0;
		value_nxt  = '0;
		status_nxt = bat_pkg::ST_READ_MISS;
		if (item_s1.cmd == bat_pkg::CMD_ADD) begin
			if (cur.id == item_s1.id) begin
				new_entry.id    = item_s1.id;
				new_entry.blame = cur.blame + item_s1.amount;
				upd             = 1'b1;
				status_nxt      = bat_pkg::ST_ADD_MATCH;
			end else if (cur.id == '0) begin
				new_entry.id    = item_s1.id;
				new_entry.blame = item_s1.amount;
				upd             = 1'b1;
				status_nxt      = bat_pkg::ST_ADD_INSERT;
			end else begin
				status_nxt      = bat_pkg::ST_ADD_DROP;
			end
		end else begin
			if (cur.id == item_s1.id) begin
				value_nxt  = cur.blame;
				upd        = 1'b1;
				status_nxt = bat_pkg::ST_READ_HIT;
			end
		end
	end

	assign mem_we    = clearing_q || item_wr;
	assign mem_waddr = clearing_q ? clr_idx_q : idx_s1;
	assign mem_wdata = clearing_q ? bat_pkg::entry_t'('0) : new_entry;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (pop)    rd_data_q <= mem[head_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_idx_q   <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				if (clr_idx_q == IDX_W'(TABLE_DEPTH - 1)) clearing_q <= 1'b0;
				else                                      clr_idx_q  <= clr_idx_q + 1'b1;
			end
			if (advance) begin
				valid_s1    <= pop;
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1     <= head_item;
			idx_s1      <= head_idx;
			fwd_sel_s1  <= item_wr && (head_idx == idx_s1);
			fwd_data_s1 <= new_entry;
		end
		if (advance && valid_s1) begin
			value_q  <= value_nxt;
			status_q <= status_nxt;
		end
	end

	assign clear_busy  = clearing_q;
	assign out_valid   = out_valid_q;
	assign blame_value = value_q;
	assign status      = status_q;

endmodule

FILE: rtl/blame_accumulator_table.sv
// ----------------------------------------------------------------------------
// blame_accumulator_table
// Direct-mapped per-object blame accumulator with add and read-and-clear.
// ----------------------------------------------------------------------------
// After reset the block sweeps the table to zero, one entry a cycle, and
// holds in_stall high meanwhile. From then on it takes one command beat per
// cycle while the result output is not stalled and returns one result beat
// per command, in order. Three front stages reduce the identifier to an index,
// the beat passes through the 4-entry queue, and the back end reads the table
// memory and updates the entry while loading the result register. The single
// memory write port and the write-to-read forwarding path let consecutive
// commands to the same entry issue back to back.
module blame_accumulator_table #(
	parameter int TABLE_DEPTH = bat_pkg::TABLE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          command,
	input  logic [bat_pkg::ADDR_W-1:0]    object_address,
	input  logic [bat_pkg::BLAME_W-1:0]   metric_amount,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bat_pkg::BLAME_W-1:0]   blame_value,
	output logic [bat_pkg::STATUS_W-1:0]  status
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int Q_W   = $bits(bat_pkg::item_t) + IDX_W;

	logic             clear_busy;
	logic             q_full, q_not_empty, q_push, q_pop;
	bat_pkg::item_t   push_item, head_item;
	logic [IDX_W-1:0] push_idx, head_idx;
	logic [Q_W-1:0]   q_head;

	bat_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.object_address (object_address),
		.metric_amount  (metric_amount),
		.block          (clear_busy),
		.q_full         (q_full),
		.push           (q_push),
		.push_item      (push_item),
		.push_idx       (push_idx)
	);

	bat_queue #(.W(Q_W)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({push_item, push_idx}),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	assign head_item = q_head[Q_W-1:IDX_W];
	assign head_idx  = q_head[IDX_W-1:0];

	bat_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (q_not_empty),
		.head_item   (head_item),
		.head_idx    (head_idx),
		.pop         (q_pop),
		.clear_busy  (clear_busy),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.blame_value (blame_value),
		.status      (status)
	);

endmodule

FILE: rtl/bat_checker.sv
// ----------------------------------------------------------------------------
// bat_checker
// Port-level checks of the blame accumulator table, bound to the top level.
// ----------------------------------------------------------------------------
module bat_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic [bat_pkg::BLAME_W-1:0]   blame_value,
	input logic [bat_pkg::STATUS_W-1:0]  status,
	input logic                          out_valid,
	input logic                          out_stall
);

	logic quiet;
	assign quiet = !(in_valid && !in_stall) && !out_valid;

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(blame_value) && $stable(status))
		else $error("result beat changed while stalled");

	// Only a read hit carries blame
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != bat_pkg::ST_READ_HIT |-> blame_value == '0)
		else $error("nonzero blame on a result other than a read hit");

	// No beat accepted and none shown throughout the checked history: nothing left inside
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		quiet && $past(quiet, 1) && $past(quiet, 2) && $past(quiet, 3) &&
		$past(quiet, 4) && $past(quiet, 5) && $past(quiet, 6) && $past(quiet, 7)
		|=> !out_valid)
		else $error("result beat without an accepted command");

endmodule

bind blame_accumulator_table bat_checker u_chk (.*);

FILE: verif/blame_accumulator_table_test.sv
// ----------------------------------------------------------------------------
// blame_accumulator_table_test
// Self-checking bench for the blame accumulator table. Directed beats cover
// the zero identifier, wraparound, collisions, the index-zero owner and
// back-to-back updates of one entry. Random beats then hammer a few shared
// table slots under random idling on both sides and one long output hold-off.
// Every result beat is checked against a shadow copy of the table.
// ----------------------------------------------------------------------------
module blame_accumulator_table_test;

	localparam int unsigned DEPTH         = bat_pkg::TABLE_DEPTH_DEF;
	localparam int          LATENCY       = 6;
	localparam int          HOLD_OFF_LEN  = 200;
	localparam longint      LIMIT_CYCLES  = 600000;
	localparam int          HOT_IDS       = 8;

	typedef struct {
		logic [bat_pkg::BLAME_W-1:0]  blame;
		logic [bat_pkg::STATUS_W-1:0] status;
	} blame_result_t;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic                          command;
	logic [bat_pkg::ADDR_W-1:0]    object_address;
	logic [bat_pkg::BLAME_W-1:0]   metric_amount;
	logic                          out_valid;
	logic                          out_stall;
	logic [bat_pkg::BLAME_W-1:0]   blame_value;
	logic [bat_pkg::STATUS_W-1:0]  status;

	bat_pkg::entry_t shadow_entries [int unsigned];
	blame_result_t   expected_blame_results [$];
	logic [bat_pkg::ID_W-1:0] hot_ids [HOT_IDS];
	int            fail_count = 0;
	bit            src_jitter = 1'b0;
	bit            sink_jitter = 1'b0;
	bit            hold_off_request = 1'b0;

	blame_accumulator_table #(
		.TABLE_DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.object_address(object_address),
		.metric_amount(metric_amount),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.blame_value(blame_value),
		.status(status)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Apply one command to the shadow table and return the result it causes
	function automatic blame_result_t apply_blame_command(input logic cmd,
			input logic [bat_pkg::ADDR_W-1:0] addr,
			input logic [bat_pkg::BLAME_W-1:0] amount);
		blame_result_t r;
		logic [bat_pkg::ID_W-1:0] id;
		int unsigned slot;
		bat_pkg::entry_t e;
		id = addr[bat_pkg::ADDR_W-1:2];
		slot = id % DEPTH;
		e = shadow_entries.exists(slot) ? shadow_entries[slot] : '0;
		r.blame = '0;
		if (cmd == bat_pkg::CMD_ADD) begin
			if (e.id == id) begin
				e.blame = e.blame + amount;
				r.status = bat_pkg::ST_ADD_MATCH;
			end else if (e.id == '0) begin
				e.id = id;
				e.blame = amount;
				r.status = bat_pkg::ST_ADD_INSERT;
			end else begin
				r.status = bat_pkg::ST_ADD_DROP;
			end
		end else if (e.id == id) begin
			r.blame = e.blame;
			e = '0;
			r.status = bat_pkg::ST_READ_HIT;
		end else begin
			r.status = bat_pkg::ST_READ_MISS;
		end
		shadow_entries[slot] = e;
		return r;
	endfunction

	// Called at a rising edge; returns at the edge that accepts the beat
	task automatic send_beat(input logic cmd, input logic [bat_pkg::ADDR_W-1:0] addr,
			input logic [bat_pkg::BLAME_W-1:0] amount);
		if (src_jitter && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		object_address <= addr;
		metric_amount <= amount;
		do @(posedge clk); while (in_stall);
		expected_blame_results.push_back(apply_blame_command(cmd, addr, amount));
	endtask

	function automatic logic [bat_pkg::BLAME_W-1:0] pick_amount();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 15);
			1: return 32'hFFFF_FFFF - $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	// Spread the hot identifiers over a few slots so that they share entries
	function automatic void refresh_hot_ids();
		int unsigned slot;
		for (int i = 0; i < HOT_IDS; i++) begin
			case (i % 4)
				0: slot = 0;
				1: slot = DEPTH - 1;
				default: slot = $urandom_range(0, DEPTH - 1);
			endcase
			hot_ids[i] = bat_pkg::ID_W'(slot + DEPTH *
				$urandom_range(0, ((2 ** bat_pkg::ID_W) - 1 - slot) / DEPTH));
		end
	endfunction

	function automatic logic [bat_pkg::ADDR_W-1:0] pick_address();
		if ($urandom_range(0, 99) < 85)
			return {hot_ids[$urandom_range(0, HOT_IDS - 1)], 2'($urandom_range(0, 3))};
		return $urandom;
	endfunction

	task automatic send_random_beat();
		send_beat($urandom_range(0, 9) < 7 ? bat_pkg::CMD_ADD : bat_pkg::CMD_READ,
			pick_address(), pick_amount());
	endtask

	task automatic test_identifier_zero();
		// Addresses below 4 match the empty mark and accumulate with wraparound
		send_beat(bat_pkg::CMD_ADD, 32'h0000_0000, 32'hFFFF_FFFF);
		send_beat(bat_pkg::CMD_ADD, 32'h0000_0003, 32'h0000_0002);
		send_beat(bat_pkg::CMD_READ, 32'h0000_0001, 32'hFFFF_FFFF);
		send_beat(bat_pkg::CMD_READ, 32'h0000_0002, 32'h0000_0000);
	endtask

	task automatic test_collision();
		send_beat(bat_pkg::CMD_ADD, 32'hFFFF_FFFC, 32'h0000_0005);
		send_beat(bat_pkg::CMD_ADD, 32'hFFF7_FFFF, 32'hFFFF_FFFF);
		send_beat(bat_pkg::CMD_READ, 32'hFFF7_FFFD, 32'h0000_0000);
		send_beat(bat_pkg::CMD_ADD, 32'hFFFF_FFFE, 32'h8000_0000);
		send_beat(bat_pkg::CMD_READ, 32'hFFFF_FFFD, 32'h0000_0000);
		send_beat(bat_pkg::CMD_READ, 32'hFFFF_FFFF, 32'h0000_0000);
	endtask

	task automatic test_index_zero_owner();
		// A real object owns slot zero, so identifier zero no longer matches
		send_beat(bat_pkg::CMD_ADD, DEPTH << 2, 32'h0000_0007);
		send_beat(bat_pkg::CMD_ADD, 32'h0000_0000, 32'h0000_0001);
		send_beat(bat_pkg::CMD_READ, 32'h0000_0000, 32'h0000_0000);
		send_beat(bat_pkg::CMD_READ, DEPTH << 2, 32'h0000_0000);
	endtask

	task automatic test_back_to_back();
		send_beat(bat_pkg::CMD_ADD, 32'h1234_5678, 32'd1);
		send_beat(bat_pkg::CMD_ADD, 32'h1234_5679, 32'd2);
		send_beat(bat_pkg::CMD_ADD, 32'h1234_567A, 32'd3);
		send_beat(bat_pkg::CMD_READ, 32'h1234_567B, 32'd0);
		send_beat(bat_pkg::CMD_ADD, 32'h1234_5678, 32'd9);
		send_beat(bat_pkg::CMD_READ, 32'h1234_5678, 32'd0);
	endtask

	task automatic test_random_traffic(input int beats);
		for (int i = 0; i < beats; i++) begin
			if (i % 50 == 0)
				refresh_hot_ids();
			send_random_beat();
		end
	endtask

	task automatic test_backpressure(input int beats);
		// Hold the output off while beats keep coming until the input stalls
		hold_off_request = 1'b1;
		for (int i = 0; i < beats; i++)
			send_random_beat();
	endtask

	task automatic test_streaming(input int beats);
		refresh_hot_ids();
		for (int i = 0; i < beats; i++)
			send_random_beat();
	endtask

	initial begin : sink_pacing
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_request) begin
				out_stall <= 1'b1;
				repeat (HOLD_OFF_LEN) @(posedge clk);
				out_stall <= 1'b0;
				hold_off_request = 1'b0;
			end else if (sink_jitter && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				out_stall <= 1'b0;
			end else if (sink_jitter) begin
				repeat ($urandom_range(0, 20)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : result_check
		blame_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_blame_results.size() == 0) begin
				$error("unexpected result beat: blame_value=%0h status=%0d",
					blame_value, status);
				fail_count++;
			end else begin
				want = expected_blame_results.pop_front();
				if (blame_value !== want.blame) begin
					$error("blame_value: expected %0h, got %0h", want.blame, blame_value);
					fail_count++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
			end
		end
	end

	initial begin : watchdog
		#(12 * LIMIT_CYCLES);
		$display("Some tests failed");
		$finish;
	end

	initial begin : main
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = bat_pkg::CMD_ADD;
		object_address = '0;
		metric_amount = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_identifier_zero();
		test_collision();
		test_index_zero_owner();
		test_back_to_back();

		src_jitter = 1'b1;
		sink_jitter = 1'b1;
		test_random_traffic(300);

		src_jitter = 1'b0;
		sink_jitter = 1'b0;
		test_backpressure(30);
		test_streaming(70);
		in_valid <= 1'b0;

		while (expected_blame_results.size() != 0)
			@(posedge clk);
		repeat (4 * LATENCY) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/bat_pkg.sv
rtl/bat_front.sv
rtl/bat_queue.sv
rtl/bat_back.sv
rtl/blame_accumulator_table.sv
rtl/bat_checker.sv
verif/blame_accumulator_table_test.sv
